// ----- src/e2g_pkg.sv -----
package e2g_pkg;

   // Field and register widths
   localparam int COORD_BITS  = 40;
   localparam int ANGLE_W     = 32;
   localparam int ALT_W       = 40;
   localparam int AXIS_W      = 33;
   localparam int ECC_W       = 34;
   localparam int LIMIT_W     = 4;
   localparam int THRESH_W    = 16;
   localparam int CSR_DATA_W  = 34;
   localparam int CSR_INDEX_W = 2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SEMI_MAJOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECC_SQ     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITER_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD  = 2'd3;

   // Register reset values (WGS84)
   localparam logic [AXIS_W-1:0]   SEMI_MAJOR_RST = 33'd6378137000;
   localparam logic [ECC_W-1:0]    ECC_SQ_RST     = 34'd7360548640;
   localparam logic [LIMIT_W-1:0]  ITER_LIMIT_RST = 4'd10;
   localparam logic [THRESH_W-1:0] THRESHOLD_RST  = 16'd1;

   // Unit step counts
   localparam int CORDIC_STEPS = 32;
   localparam int MUL_STEPS    = 4;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 80;
   localparam int CNT_W        = 7;

   // Fixed-point constants
   localparam logic [63:0]        KINV_Q32  = 64'd2608131496;
   localparam logic signed [63:0] KINV_Q30  = 64'sd652032874;
   localparam logic [63:0]        ONE_Q40   = 64'h0000_0100_0000_0000;
   localparam logic [31:0]        COS_TINY  = 32'd1024;
   localparam logic [63:0]        QUOT_SAT  = 64'h0001_0000_0000_0000;
   localparam logic signed [31:0] QUARTER   = 32'sd1073741824;
   localparam logic signed [63:0] ALT_MAX   = 64'sd549755813887;
   localparam logic signed [63:0] ALT_MIN   = -64'sd549755813888;

   // Datapath operations; the controller state carries the same codes
   localparam logic [3:0] OP_IDLE     = 4'd0;
   localparam logic [3:0] OP_VEC_LON  = 4'd1;
   localparam logic [3:0] OP_MUL_P    = 4'd2;
   localparam logic [3:0] OP_MUL_PE   = 4'd3;
   localparam logic [3:0] OP_VEC_LAT0 = 4'd4;
   localparam logic [3:0] OP_ROT      = 4'd5;
   localparam logic [3:0] OP_MUL_S2   = 4'd6;
   localparam logic [3:0] OP_MUL_ES2  = 4'd7;
   localparam logic [3:0] OP_SQRT     = 4'd8;
   localparam logic [3:0] OP_DIV_N    = 4'd9;
   localparam logic [3:0] OP_MUL_EN   = 4'd10;
   localparam logic [3:0] OP_MUL_T    = 4'd11;
   localparam logic [3:0] OP_VEC_LAT  = 4'd12;
   localparam logic [3:0] OP_DIV_ALT  = 4'd13;
   localparam logic [3:0] OP_MUL_SUB  = 4'd14;
   localparam logic [3:0] OP_FINISH   = 4'd15;

   typedef struct packed {
      logic       load;
      logic       go;
      logic [3:0] op;
   } e2g_cmd_type;

   typedef struct packed {
      logic done;
      logic conv;
   } e2g_stat_type;

   // CORDIC arctangent table, binary angle units
   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

endpackage

// ----- src/e2g_datapath.sv -----
module e2g_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  e2g_pkg::e2g_cmd_type                   cmd,
   output e2g_pkg::e2g_stat_type                  stat,
   input  logic signed [e2g_pkg::COORD_BITS-1:0]  pos_x,
   input  logic signed [e2g_pkg::COORD_BITS-1:0]  pos_y,
   input  logic signed [e2g_pkg::COORD_BITS-1:0]  pos_z,
   input  logic [e2g_pkg::AXIS_W-1:0]             semi_major,
   input  logic [e2g_pkg::ECC_W-1:0]              ecc_sq,
   input  logic [e2g_pkg::THRESH_W-1:0]           thresh,
   output logic signed [e2g_pkg::ANGLE_W-1:0]     lat_out,
   output logic signed [e2g_pkg::ANGLE_W-1:0]     lon_out,
   output logic signed [e2g_pkg::ALT_W-1:0]       alt_out,
   output logic                                   polar_out
);

   // Sequencing
   logic [3:0]                     op_ff;
   logic                           run_ff;
   logic [e2g_pkg::CNT_W-1:0]      cnt_ff;
   logic                           done;

   // Working values
   logic signed [63:0] xq_ff, yq_ff, zq_ff;
   logic [63:0]        pq_ff, ta_ff, tb_ff, nq_ff;
   logic signed [31:0] lat_ff, sin_ff, cos_ff;
   logic [31:0]        lon_ff;
   logic               polar_ff, dsat_ff;

   // CORDIC
   logic signed [63:0] cx_ff, cy_ff, cx_in, cy_in, dx, dy;
   logic signed [33:0] cz_ff, cz_in, at;
   logic               czero_ff, cvec_ff, cw;
   logic signed [63:0] vx, vy;

   // Multiplier
   logic [63:0]  ma_ff, mb_ff, ma_sel, mb_sel, pp;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  pa, pb;
   logic [1:0]   psum;
   logic [63:0]  mres30, mres32, mres40;

   // Square root
   logic [63:0] sv_ff, sres_ff, sbit_ff, sv_in, sres_in, ssum, sq_arg;
   logic        sge;

   // Divider
   logic [79:0] dnum_ff, dnum_in;
   logic [32:0] drem_ff, dden_ff, drem_in;
   logic [33:0] dt, dt_sub;
   logic        dge;
   logic [63:0] dn_sel, dd_ext;
   logic [31:0] dd_sel;
   logic        polar_now;

   // Misc combinational
   logic [31:0]        sin_mag, cos_mag, vec_ang;
   logic [63:0]        zmag, vec_mag;
   logic [40:0]        one_e2;
   logic signed [63:0] w_sel;
   logic signed [31:0] new_lat;
   logic signed [32:0] dlat;
   logic [32:0]        dlat_mag;
   logic signed [63:0] altq, alt_r;
   logic [39:0]        alt_sat;

   // Last counter value for each operation
   function automatic logic [e2g_pkg::CNT_W-1:0] op_last(input logic [3:0] op);
      logic [e2g_pkg::CNT_W-1:0] n;
      case (op)
         e2g_pkg::OP_VEC_LON, e2g_pkg::OP_VEC_LAT0, e2g_pkg::OP_VEC_LAT,
         e2g_pkg::OP_ROT: n = e2g_pkg::CNT_W'(e2g_pkg::CORDIC_STEPS);
         e2g_pkg::OP_MUL_P, e2g_pkg::OP_MUL_PE, e2g_pkg::OP_MUL_S2,
         e2g_pkg::OP_MUL_ES2, e2g_pkg::OP_MUL_EN, e2g_pkg::OP_MUL_T,
         e2g_pkg::OP_MUL_SUB: n = e2g_pkg::CNT_W'(e2g_pkg::MUL_STEPS);
         e2g_pkg::OP_SQRT: n = e2g_pkg::CNT_W'(e2g_pkg::SQRT_STEPS);
         e2g_pkg::OP_DIV_N, e2g_pkg::OP_DIV_ALT: n = e2g_pkg::CNT_W'(e2g_pkg::DIV_STEPS);
         default: n = '0;
      endcase
      return n;
   endfunction

   // Wrap to signed and clamp to the quarter turn
   function automatic logic signed [31:0] lat_clamp(input logic [31:0] a);
      logic signed [31:0] v;
      v = a;
      if (v > e2g_pkg::QUARTER) begin
         v = e2g_pkg::QUARTER;
      end else if (v < -e2g_pkg::QUARTER) begin
         v = -e2g_pkg::QUARTER;
      end
      return v;
   endfunction

   assign done      = run_ff && (cnt_ff == op_last(op_ff));
   assign stat.done = done;

   // Magnitudes and shared operands
   always_comb begin
      sin_mag = sin_ff[31] ? -sin_ff : sin_ff;
      cos_mag = cos_ff[31] ? -cos_ff : cos_ff;
      zmag    = zq_ff[63] ? -zq_ff : zq_ff;
      one_e2  = e2g_pkg::ONE_Q40[40:0] - {7'b0, ecc_sq};
      w_sel   = sin_ff[31] ? zq_ff - $signed(ta_ff) : zq_ff + $signed(ta_ff);
      polar_now = cos_mag < e2g_pkg::COS_TINY;
      sq_arg  = (e2g_pkg::ONE_Q40 - ta_ff) << 20;
   end

   // Vectoring operand select
   always_comb begin
      case (cmd.op)
         e2g_pkg::OP_VEC_LON: begin
            vx = xq_ff;
            vy = yq_ff;
         end
         e2g_pkg::OP_VEC_LAT0: begin
            vx = $signed(ta_ff);
            vy = zq_ff;
         end
         default: begin
            vx = $signed(pq_ff);
            vy = w_sel;
         end
      endcase
   end

   // Multiplier operand select
   always_comb begin
      case (cmd.op)
         e2g_pkg::OP_MUL_P: begin
            ma_sel = ta_ff;
            mb_sel = e2g_pkg::KINV_Q32;
         end
         e2g_pkg::OP_MUL_PE: begin
            ma_sel = pq_ff;
            mb_sel = {23'b0, one_e2};
         end
         e2g_pkg::OP_MUL_S2: begin
            ma_sel = {32'b0, sin_mag};
            mb_sel = {32'b0, sin_mag};
         end
         e2g_pkg::OP_MUL_ES2: begin
            ma_sel = {30'b0, ecc_sq};
            mb_sel = ta_ff;
         end
         e2g_pkg::OP_MUL_EN: begin
            ma_sel = {30'b0, ecc_sq};
            mb_sel = nq_ff;
         end
         e2g_pkg::OP_MUL_T: begin
            ma_sel = ta_ff;
            mb_sel = {32'b0, sin_mag};
         end
         default: begin
            ma_sel = nq_ff;
            mb_sel = {23'b0, one_e2};
         end
      endcase
   end

   // Altitude divide operands and saturation test
   always_comb begin
      dn_sel = polar_now ? zmag : pq_ff;
      dd_sel = polar_now ? sin_mag : cos_mag;
      dd_ext = {14'b0, dd_sel, 18'b0};
   end

   // CORDIC step: one micro-rotation per cycle
   always_comb begin
      dx    = cx_ff >>> cnt_ff[4:0];
      dy    = cy_ff >>> cnt_ff[4:0];
      at    = $signed({2'b00, e2g_pkg::ATAN_TAB[cnt_ff[4:0]]});
      cw    = cvec_ff ? ~cy_ff[63] : cz_ff[33];
      cx_in = cw ? cx_ff + dy : cx_ff - dy;
      cy_in = cw ? cy_ff - dx : cy_ff + dx;
      cz_in = cw ? cz_ff + at : cz_ff - at;
      vec_ang = czero_ff ? 32'd0 : cz_ff[31:0];
      vec_mag = czero_ff ? 64'd0 : cx_ff;
      new_lat = lat_clamp(vec_ang);
      dlat    = {new_lat[31], new_lat} - {lat_ff[31], lat_ff};
      dlat_mag = dlat[32] ? -dlat : dlat;
   end

   assign stat.conv = dlat_mag < {17'b0, thresh};

   // Multiplier step: one 32x32 partial product per cycle
   always_comb begin
      pa     = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      pb     = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp     = pa * pb;
      psum   = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
      acc_in = acc_ff + ({64'b0, pp} << {psum, 5'b0});
      mres30 = (|acc_ff[127:94])  ? '1 : acc_ff[93:30];
      mres32 = (|acc_ff[127:96])  ? '1 : acc_ff[95:32];
      mres40 = (|acc_ff[127:104]) ? '1 : acc_ff[103:40];
   end

   // Square root step: one result bit per cycle
   always_comb begin
      ssum    = sres_ff + sbit_ff;
      sge     = sv_ff >= ssum;
      sv_in   = sge ? sv_ff - ssum : sv_ff;
      sres_in = sge ? (sres_ff >> 1) + sbit_ff : sres_ff >> 1;
   end

   // Restoring divider step: one quotient bit per cycle
   always_comb begin
      dt      = {drem_ff, dnum_ff[79]};
      dt_sub  = dt - {1'b0, dden_ff};
      dge     = dt >= {1'b0, dden_ff};
      drem_in = dge ? dt_sub[32:0] : dt[32:0];
      dnum_in = {dnum_ff[78:0], dge};
   end

   // Altitude: round from mm*2^8 and saturate
   always_comb begin
      altq  = $signed(tb_ff) - $signed(polar_ff ? ta_ff : nq_ff);
      alt_r = (altq + 64'sd128) >>> 8;
      if (alt_r > e2g_pkg::ALT_MAX) begin
         alt_sat = e2g_pkg::ALT_MAX[39:0];
      end else if (alt_r < e2g_pkg::ALT_MIN) begin
         alt_sat = e2g_pkg::ALT_MIN[39:0];
      end else begin
         alt_sat = alt_r[39:0];
      end
   end

   // Operation sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
         op_ff  <= e2g_pkg::OP_IDLE;
      end else if (cmd.go) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
         op_ff  <= cmd.op;
      end else if (done) begin
         run_ff <= 1'b0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Input capture, mm scaled by 2^8
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xq_ff <= {{(64-e2g_pkg::COORD_BITS){pos_x[e2g_pkg::COORD_BITS-1]}}, pos_x} <<< 8;
         yq_ff <= {{(64-e2g_pkg::COORD_BITS){pos_y[e2g_pkg::COORD_BITS-1]}}, pos_y} <<< 8;
         zq_ff <= {{(64-e2g_pkg::COORD_BITS){pos_z[e2g_pkg::COORD_BITS-1]}}, pos_z} <<< 8;
      end
   end

   // Unit setup, steps and writeback
   always_ff @(posedge clock) begin
      if (cmd.go) begin
         case (cmd.op)
            e2g_pkg::OP_VEC_LON, e2g_pkg::OP_VEC_LAT0, e2g_pkg::OP_VEC_LAT: begin
               cvec_ff  <= 1'b1;
               czero_ff <= (vx == 64'sd0) && (vy == 64'sd0);
               cx_ff    <= vx[63] ? -vx : vx;
               cy_ff    <= vx[63] ? -vy : vy;
               cz_ff    <= vx[63] ? 34'sh080000000 : 34'sd0;
            end
            e2g_pkg::OP_ROT: begin
               cvec_ff  <= 1'b0;
               czero_ff <= 1'b0;
               cx_ff    <= e2g_pkg::KINV_Q30;
               cy_ff    <= 64'sd0;
               cz_ff    <= {{2{lat_ff[31]}}, lat_ff};
            end
            e2g_pkg::OP_MUL_P, e2g_pkg::OP_MUL_PE, e2g_pkg::OP_MUL_S2,
            e2g_pkg::OP_MUL_ES2, e2g_pkg::OP_MUL_EN, e2g_pkg::OP_MUL_T,
            e2g_pkg::OP_MUL_SUB: begin
               ma_ff  <= ma_sel;
               mb_ff  <= mb_sel;
               acc_ff <= '0;
            end
            e2g_pkg::OP_SQRT: begin
               sv_ff   <= sq_arg;
               sres_ff <= '0;
               sbit_ff <= 64'h4000_0000_0000_0000;
            end
            e2g_pkg::OP_DIV_N: begin
               dnum_ff <= {9'b0, semi_major, 38'b0};
               drem_ff <= '0;
               dden_ff <= tb_ff[32:0];
               dsat_ff <= 1'b0;
            end
            e2g_pkg::OP_DIV_ALT: begin
               polar_ff <= polar_now;
               dnum_ff  <= {dn_sel[49:0], 30'b0};
               drem_ff  <= '0;
               dden_ff  <= {1'b0, dd_sel};
               dsat_ff  <= (dd_sel == 32'd0) || (dn_sel >= dd_ext);
            end
            default: begin
            end
         endcase
      end else if (run_ff && !done) begin
         case (op_ff)
            e2g_pkg::OP_VEC_LON, e2g_pkg::OP_VEC_LAT0, e2g_pkg::OP_VEC_LAT,
            e2g_pkg::OP_ROT: begin
               cx_ff <= cx_in;
               cy_ff <= cy_in;
               cz_ff <= cz_in;
            end
            e2g_pkg::OP_SQRT: begin
               sv_ff   <= sv_in;
               sres_ff <= sres_in;
               sbit_ff <= sbit_ff >> 2;
            end
            e2g_pkg::OP_DIV_N, e2g_pkg::OP_DIV_ALT: begin
               drem_ff <= drem_in;
               dnum_ff <= dnum_in;
            end
            default: begin
               acc_ff <= acc_in;
            end
         endcase
      end else if (done) begin
         case (op_ff)
            e2g_pkg::OP_VEC_LON: begin
               lon_ff <= vec_ang;
               ta_ff  <= vec_mag;
            end
            e2g_pkg::OP_MUL_P:    pq_ff <= mres32;
            e2g_pkg::OP_MUL_PE:   ta_ff <= mres40;
            e2g_pkg::OP_VEC_LAT0: lat_ff <= new_lat;
            e2g_pkg::OP_ROT: begin
               sin_ff <= cy_ff[31:0];
               cos_ff <= cx_ff[31:0];
            end
            e2g_pkg::OP_MUL_S2:   ta_ff <= mres30;
            e2g_pkg::OP_MUL_ES2:  ta_ff <= mres30;
            e2g_pkg::OP_SQRT:     tb_ff <= (sres_ff == 64'd0) ? 64'd1 : sres_ff;
            e2g_pkg::OP_DIV_N:    nq_ff <= dnum_ff[63:0];
            e2g_pkg::OP_MUL_EN:   ta_ff <= mres40;
            e2g_pkg::OP_MUL_T:    ta_ff <= mres30;
            e2g_pkg::OP_VEC_LAT:  lat_ff <= new_lat;
            e2g_pkg::OP_DIV_ALT:  tb_ff <= dsat_ff ? e2g_pkg::QUOT_SAT : dnum_ff[63:0];
            e2g_pkg::OP_MUL_SUB:  ta_ff <= mres40;
            e2g_pkg::OP_FINISH: begin
               lat_out   <= lat_ff;
               lon_out   <= lon_ff;
               alt_out   <= alt_sat;
               polar_out <= polar_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- src/e2g_ctrl.sv -----
module e2g_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [e2g_pkg::LIMIT_W-1:0]      iter_limit,
   input  e2g_pkg::e2g_stat_type            stat,
   output e2g_pkg::e2g_cmd_type             cmd,
   output logic                             rsp_valid,
   output logic [e2g_pkg::LIMIT_W-1:0]      iters_used
);

   logic [3:0]                  state_ff, state_in;
   logic                        issued_ff, issued_in;
   logic                        final_ff, final_in;
   logic [e2g_pkg::LIMIT_W-1:0] used_ff, used_in;
   logic                        valid_ff, valid_in;
   logic [e2g_pkg::LIMIT_W-1:0] limit_eff;

   assign limit_eff  = (iter_limit == '0) ? 4'd1 : iter_limit;
   assign busy       = state_ff != e2g_pkg::OP_IDLE;
   assign cmd.op     = state_ff;
   assign cmd.go     = busy && !issued_ff;
   assign cmd.load   = !busy && start;
   assign rsp_valid  = valid_ff;
   assign iters_used = used_ff;

   // Next state: each state runs one datapath operation
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      final_in  = final_ff;
      used_in   = used_ff;
      valid_in  = 1'b0;
      if (cmd.go) begin
         issued_in = 1'b1;
      end
      if (cmd.load) begin
         state_in = e2g_pkg::OP_VEC_LON;
         final_in = 1'b0;
         used_in  = '0;
      end else if (stat.done) begin
         issued_in = 1'b0;
         case (state_ff)
            e2g_pkg::OP_VEC_LON:  state_in = e2g_pkg::OP_MUL_P;
            e2g_pkg::OP_MUL_P:    state_in = e2g_pkg::OP_MUL_PE;
            e2g_pkg::OP_MUL_PE:   state_in = e2g_pkg::OP_VEC_LAT0;
            e2g_pkg::OP_VEC_LAT0: state_in = e2g_pkg::OP_ROT;
            e2g_pkg::OP_ROT:      state_in = e2g_pkg::OP_MUL_S2;
            e2g_pkg::OP_MUL_S2:   state_in = e2g_pkg::OP_MUL_ES2;
            e2g_pkg::OP_MUL_ES2:  state_in = e2g_pkg::OP_SQRT;
            e2g_pkg::OP_SQRT:     state_in = e2g_pkg::OP_DIV_N;
            e2g_pkg::OP_DIV_N: begin
               state_in = final_ff ? e2g_pkg::OP_DIV_ALT : e2g_pkg::OP_MUL_EN;
            end
            e2g_pkg::OP_MUL_EN:   state_in = e2g_pkg::OP_MUL_T;
            e2g_pkg::OP_MUL_T:    state_in = e2g_pkg::OP_VEC_LAT;
            e2g_pkg::OP_VEC_LAT: begin
               // refinement pass done; stop on convergence or at the limit
               state_in = e2g_pkg::OP_ROT;
               used_in  = used_ff + 1'b1;
               final_in = stat.conv || (used_in == limit_eff);
            end
            e2g_pkg::OP_DIV_ALT:  state_in = e2g_pkg::OP_MUL_SUB;
            e2g_pkg::OP_MUL_SUB:  state_in = e2g_pkg::OP_FINISH;
            e2g_pkg::OP_FINISH: begin
               state_in = e2g_pkg::OP_IDLE;
               valid_in = 1'b1;
            end
            default: state_in = e2g_pkg::OP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= e2g_pkg::OP_IDLE;
         issued_ff <= 1'b0;
         final_ff  <= 1'b0;
         used_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         final_ff  <= final_in;
         used_ff   <= used_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

// ----- src/ecef_to_geodetic_converter_core.sv -----
// A conversion runs 1..15 refinement passes, bounded by the iteration limit register.
// One pass is CORDIC rotate, square root, divide, CORDIC vectoring and four
// multiplies; the divider and CORDIC units are bit-serial.
// Throughput: one conversion at a time; the next start is taken in the rsp_valid cycle.
// Reset (synchronous, active high) idles the controller and loads WGS84 registers.
// rsp_valid is a single-cycle strobe; the receiver cannot stall.
module ecef_to_geodetic_converter_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [e2g_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [e2g_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic signed [e2g_pkg::COORD_BITS-1:0] req_pos_z,
   output logic                                  rsp_valid,
   output logic signed [e2g_pkg::ANGLE_W-1:0]    rsp_latitude,
   output logic signed [e2g_pkg::ANGLE_W-1:0]    rsp_longitude,
   output logic signed [e2g_pkg::ALT_W-1:0]      rsp_altitude,
   output logic [e2g_pkg::LIMIT_W-1:0]           rsp_iterations_used,
   output logic                                  rsp_polar_case,
   input  logic                                  csr_we,
   input  logic [e2g_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [e2g_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   logic [e2g_pkg::AXIS_W-1:0]   semi_major_ff;
   logic [e2g_pkg::ECC_W-1:0]    ecc_sq_ff;
   logic [e2g_pkg::LIMIT_W-1:0]  iter_limit_ff;
   logic [e2g_pkg::THRESH_W-1:0] thresh_ff;

   e2g_pkg::e2g_cmd_type  cmd;
   e2g_pkg::e2g_stat_type stat;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         semi_major_ff <= e2g_pkg::SEMI_MAJOR_RST;
         ecc_sq_ff     <= e2g_pkg::ECC_SQ_RST;
         iter_limit_ff <= e2g_pkg::ITER_LIMIT_RST;
         thresh_ff     <= e2g_pkg::THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            e2g_pkg::CSR_SEMI_MAJOR: semi_major_ff <= csr_wdata[e2g_pkg::AXIS_W-1:0];
            e2g_pkg::CSR_ECC_SQ:     ecc_sq_ff     <= csr_wdata[e2g_pkg::ECC_W-1:0];
            e2g_pkg::CSR_ITER_LIMIT: iter_limit_ff <= csr_wdata[e2g_pkg::LIMIT_W-1:0];
            e2g_pkg::CSR_THRESHOLD:  thresh_ff     <= csr_wdata[e2g_pkg::THRESH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   e2g_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .iter_limit (iter_limit_ff),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_valid  (rsp_valid),
      .iters_used (rsp_iterations_used)
   );

   e2g_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .pos_z      (req_pos_z),
      .semi_major (semi_major_ff),
      .ecc_sq     (ecc_sq_ff),
      .thresh     (thresh_ff),
      .lat_out    (rsp_latitude),
      .lon_out    (rsp_longitude),
      .alt_out    (rsp_altitude),
      .polar_out  (rsp_polar_case)
   );

`ifndef SYNTHESIS
   // result beat only once the controller is back to idle
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");

   // strobe lasts one cycle
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // accepted start launches a conversion
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");

   // at least one pass, latitude within a quarter turn
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iterations_used != 4'd0)
         && (rsp_latitude <= e2g_pkg::QUARTER)
         && (rsp_latitude >= -e2g_pkg::QUARTER)) else $error("result out of range");
`endif

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import e2g_pkg::*;

   localparam int TIMEOUT_CYCLES = 12_000_000;

   typedef struct {
      bit signed [COORD_BITS-1:0] x;
      bit signed [COORD_BITS-1:0] y;
      bit signed [COORD_BITS-1:0] z;
   } fix_type;

   typedef struct {
      bit signed [ANGLE_W-1:0] lat;
      bit signed [ANGLE_W-1:0] lon;
      bit signed [ALT_W-1:0]   alt;
      bit [LIMIT_W-1:0]        used;
      bit                      polar;
   } geo_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [COORD_BITS-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic rsp_valid;
   logic signed [ANGLE_W-1:0] rsp_latitude, rsp_longitude;
   logic signed [ALT_W-1:0] rsp_altitude;
   logic [LIMIT_W-1:0] rsp_iterations_used;
   logic rsp_polar_case;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // local copy of the configuration registers
   longint unsigned axis_mm, ecc_q40, iter_max, conv_thr;

   fix_type pending_fixes[$];
   geo_type expected_geo[$];
   fix_type cur_fix;
   int gap;
   bit calm;
   int errors;
   longint cycles;

   ecef_to_geodetic_converter_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_latitude(rsp_latitude), .rsp_longitude(rsp_longitude),
      .rsp_altitude(rsp_altitude), .rsp_iterations_used(rsp_iterations_used),
      .rsp_polar_case(rsp_polar_case),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------- fixed-point arithmetic ----------------

   // floor(a*b / 2^s), all ones when it does not fit 64 bits
   function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b,
                                                 int s);
      bit [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> s;
      if (p[127:64] != 0) return '1;
      return p[63:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(64'd0 - v) : v;
   endfunction

   // CORDIC vectoring: angle of (x,y) and gain-scaled length
   function automatic bit [31:0] vec_angle(longint x, longint y, output longint unsigned len);
      bit [31:0] ang;
      longint dx, dy;
      ang = 0;
      if (x == 0 && y == 0) begin
         len = 0;
         return 0;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         ang = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x += dy; y -= dx; ang += ATAN_TAB[i];
         end else begin
            x -= dy; y += dx; ang -= ATAN_TAB[i];
         end
      end
      len = x;
      return ang;
   endfunction

   // CORDIC rotation, Q30 sine and cosine
   function automatic void rot_sin_cos(longint ang, output longint s, output longint c);
      longint x, y, dx, dy;
      x = KINV_Q30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (ang >= 0) begin
            x -= dy; y += dx; ang -= longint'(ATAN_TAB[i]);
         end else begin
            x += dy; y -= dx; ang += longint'(ATAN_TAB[i]);
         end
      end
      s = y;
      c = x;
   endfunction

   function automatic longint clamp_lat(bit [31:0] a);
      longint v;
      v = longint'($signed(a));
      if (v > 64'sd1073741824) v = 64'sd1073741824;
      if (v < -64'sd1073741824) v = -64'sd1073741824;
      return v;
   endfunction

   // prime vertical radius, mm * 2^8
   function automatic longint unsigned prime_radius(longint s);
      longint unsigned sm, s2, den, r, num, q, rem;
      sm = abs64(s);
      s2 = (sm * sm) >> 30;
      den = ONE_Q40 - mul_shift(ecc_q40, s2, 30);
      r = int_sqrt(den << 20);
      if (r == 0) r = 1;
      num = axis_mm << 30;
      q = num / r;
      rem = num % r;
      return (q << 8) | ((rem << 8) / r);
   endfunction

   function automatic longint unsigned quot_q30(longint unsigned num, longint unsigned den);
      longint unsigned q1, r1;
      if (den == 0 || den > (64'd1 << 32) || num >= (den << 18)) return QUOT_SAT;
      q1 = num / den;
      r1 = num % den;
      return (q1 << 30) + ((r1 << 30) / den);
   endfunction

   function automatic geo_type convert_fix(fix_type f);
      geo_type g;
      longint xq, yq, zq, lat, s, c, w, nl, diff, altq, alt;
      longint unsigned one_e2, glen, pq, nq, scratch, lim, used, en, t;
      bit [31:0] lon;
      bit polar;
      xq = longint'(f.x) * 256;
      yq = longint'(f.y) * 256;
      zq = longint'(f.z) * 256;
      one_e2 = ONE_Q40 - ecc_q40;
      used = 0;
      lon = vec_angle(xq, yq, glen);
      pq = mul_shift(glen, KINV_Q32, 32);
      lat = clamp_lat(vec_angle(longint'(mul_shift(pq, one_e2, 40)), zq, scratch));
      lim = iter_max == 0 ? 1 : iter_max;
      // latitude refinement
      for (longint unsigned k = 0; k < lim; k++) begin
         used = k + 1;
         rot_sin_cos(lat, s, c);
         nq = prime_radius(s);
         en = mul_shift(ecc_q40, nq, 40);
         t = mul_shift(en, abs64(s), 30);
         w = s >= 0 ? zq + longint'(t) : zq - longint'(t);
         nl = clamp_lat(vec_angle(longint'(pq), w, scratch));
         diff = nl > lat ? nl - lat : lat - nl;
         lat = nl;
         if (longint'(diff) < longint'(conv_thr)) break;
      end
      rot_sin_cos(lat, s, c);
      nq = prime_radius(s);
      polar = abs64(c) < 1024;
      if (polar)
         altq = longint'(quot_q30(abs64(zq), abs64(s))) - longint'(mul_shift(nq, one_e2, 40));
      else
         altq = longint'(quot_q30(pq, abs64(c))) - longint'(nq);
      alt = (altq + 128) >>> 8;
      if (alt > ALT_MAX) alt = ALT_MAX;
      if (alt < ALT_MIN) alt = ALT_MIN;
      g.lat = lat[31:0];
      g.lon = lon;
      g.alt = alt[39:0];
      g.used = used[3:0];
      g.polar = polar;
      return g;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap <= 0;
      end else begin
         if (start && !busy) expected_geo.push_back(convert_fix(cur_fix));
         if (start && busy) begin
            // hold the beat until taken
         end else if (gap > 0) begin
            start <= 1'b0;
            gap <= gap - 1;
         end else if (pending_fixes.size() > 0) begin
            cur_fix = pending_fixes.pop_front();
            req_pos_x <= cur_fix.x;
            req_pos_y <= cur_fix.y;
            req_pos_z <= cur_fix.z;
            start <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) gap <= $urandom_range(1, 5);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      geo_type e;
      if (!reset && rsp_valid) begin
         if (expected_geo.size() == 0) begin
            $display("%0t: unexpected result beat lat=%0d lon=%0d alt=%0d", $time,
                     rsp_latitude, rsp_longitude, rsp_altitude);
            errors++;
         end else begin
            e = expected_geo.pop_front();
            if (rsp_latitude !== e.lat) begin
               $display("%0t: latitude exp %0d got %0d", $time, e.lat, rsp_latitude);
               errors++;
            end
            if (rsp_longitude !== e.lon) begin
               $display("%0t: longitude exp %0d got %0d", $time, e.lon, rsp_longitude);
               errors++;
            end
            if (rsp_altitude !== e.alt) begin
               $display("%0t: altitude exp %0d got %0d", $time, e.alt, rsp_altitude);
               errors++;
            end
            if (rsp_iterations_used !== e.used) begin
               $display("%0t: iterations exp %0d got %0d", $time, e.used,
                        rsp_iterations_used);
               errors++;
            end
            if (rsp_polar_case !== e.polar) begin
               $display("%0t: polar flag exp %0d got %0d", $time, e.polar, rsp_polar_case);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic add_fix(longint x, longint y, longint z);
      fix_type f;
      f.x = x[COORD_BITS-1:0];
      f.y = y[COORD_BITS-1:0];
      f.z = z[COORD_BITS-1:0];
      pending_fixes.push_back(f);
   endtask

   task automatic set_reg(logic [CSR_INDEX_W-1:0] idx, longint unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      case (idx)
         CSR_SEMI_MAJOR: axis_mm = val & ((64'd1 << AXIS_W) - 1);
         CSR_ECC_SQ:     ecc_q40 = val & ((64'd1 << ECC_W) - 1);
         CSR_ITER_LIMIT: iter_max = val & 15;
         CSR_THRESHOLD:  conv_thr = val & 16'hFFFF;
         default: begin
         end
      endcase
   endtask

   task automatic set_all(longint unsigned a, longint unsigned e, longint unsigned l,
                          longint unsigned t);
      set_reg(CSR_SEMI_MAJOR, a);
      set_reg(CSR_ECC_SQ, e);
      set_reg(CSR_ITER_LIMIT, l);
      set_reg(CSR_THRESHOLD, t);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until the block is drained and idle
   task automatic drain();
      while (pending_fixes.size() > 0 || start || expected_geo.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic longint rand_bits(int w);
      longint v;
      v = longint'({$urandom, $urandom});
      return (v <<< (64 - w)) >>> (64 - w);
   endfunction

   task automatic add_random_fix();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1:    add_fix(rand_bits(40), rand_bits(40), rand_bits(40));
         2:       add_fix(rand_bits(12), rand_bits(12), rand_bits(34)); // near a pole
         3:       add_fix(rand_bits(34), rand_bits(34), rand_bits(10)); // near equator
         4:       add_fix(rand_bits(20), rand_bits(20), rand_bits(20));
         default: add_fix(rand_bits(34), rand_bits(34), rand_bits(34)); // around the earth
      endcase
   endtask

   task automatic random_phase(int n);
      set_all($urandom_range(0, 1000000000) + 64'd6000000000,
              {$urandom_range(0, 3), $urandom}, $urandom_range(1, 15),
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 16));
      repeat (n) add_random_fix();
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cycles = 0;
      errors = 0;
      calm = 0;
      axis_mm = SEMI_MAJOR_RST;
      ecc_q40 = ECC_SQ_RST;
      iter_max = ITER_LIMIT_RST;
      conv_thr = THRESHOLD_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers, field extremes, poles, zero vector
      add_fix(0, 0, 0);
      add_fix(64'sd6378137000, 0, 0);
      add_fix(-64'sd6378137000, 0, 0);
      add_fix(0, 64'sd6378137000, 0);
      add_fix(0, -64'sd6378137000, 0);
      add_fix(0, 0, 64'sd6356752314);
      add_fix(0, 0, -64'sd6356752314);
      add_fix(3, -2, 64'sd6356800000);
      add_fix(64'sd549755813887, 64'sd549755813887, 64'sd549755813887);
      add_fix(-64'sd549755813888, -64'sd549755813888, -64'sd549755813888);
      add_fix(-64'sd549755813888, 0, 64'sd549755813887);
      add_fix(64'sd4000000000, 64'sd3000000000, 64'sd3500000000);
      add_fix(-1, -1, -1);
      drain();

      // limit zero acts as one, threshold zero runs every pass
      set_all(64'd6000000000, 0, 0, 0);
      add_fix(64'sd4000000000, -64'sd3000000000, 64'sd3500000000);
      add_fix(0, 0, 64'sd6000000000);
      drain();
      set_all(64'd7000000000, 64'd17179869183, 15, 0);
      add_fix(64'sd4000000000, 64'sd3000000000, -64'sd3500000000);
      add_fix(64'sd100, 0, 64'sd7000000000);
      drain();
      set_all(64'd8589934591, 64'd17179869183, 15, 65535);
      add_fix(64'sd5000000000, 64'sd5000000000, 64'sd5000000000);
      add_fix(-64'sd549755813888, 64'sd549755813887, 0);
      drain();

      // random phases with assorted ellipsoids
      repeat (6) random_phase(80);
      set_all(SEMI_MAJOR_RST, ECC_SQ_RST, ITER_LIMIT_RST, THRESHOLD_RST);
      calm = 1;
      repeat (80) add_random_fix();
      drain();

      while (expected_geo.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
